FILE: rtl/bscc_pkg.sv
// shared types and constants for the bucket spray chunk chainer
// no dependencies; imported by bucket_spray_chunk_chainer_top
package bscc_pkg;

    localparam int BUCKET_BITS  = 8;
    localparam int NBUCKETS     = 1 << BUCKET_BITS;
    localparam int ENTRY_BYTES  = 38;
    localparam int LINK_BYTES   = 4;
    localparam int HEADER_BYTES = 38;
    localparam int BLOCK_LOG    = 9;
    localparam int CHUNK_RESET  = 64 * 1024;
    localparam int USABLE_RESET =
        ((CHUNK_RESET - LINK_BYTES) / ENTRY_BYTES) * ENTRY_BYTES;

    localparam int CHUNK_W = 21;
    localparam int SPAN_W  = 17;

    // reciprocal of the entry size: quotient = (x * DIV_MULT) >> DIV_SHIFT
    // exact for every x below 2^CHUNK_W
    localparam int DIV_SHIFT  = CHUNK_W + $clog2(ENTRY_BYTES);
    localparam int DIV_MULT_W = CHUNK_W + 1;
    localparam int DIV_MULT   = ((1 << DIV_SHIFT) + ENTRY_BYTES - 1) / ENTRY_BYTES;

    localparam logic [31:0] NO_LINK = 32'hFFFF_FFFF;

    // request codes
    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_CLUMP  = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ENTRY  = 2'd0;
    localparam logic [1:0] KIND_FLUSH  = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;
    localparam logic [1:0] KIND_ACK    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_SECOND,
        S_DIV,
        S_SCALE
    } t_state;

    typedef struct packed {
        logic [CHUNK_W-1:0] fill;
        logic [31:0]        head;
        logic [63:0]        total;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{fill: '0, head: NO_LINK, total: '0};

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         bucket;
        logic [CHUNK_W-1:0] slot_offset;
        logic [63:0]        entry_addr;
        logic [7:0]         entry_blocks;
        logic [31:0]        chunk_number;
        logic [31:0]        prev_link;
        logic [CHUNK_W-1:0] byte_count;
        logic [63:0]        bucket_total;
        logic [63:0]        largest_total;
        logic               last;
    } t_result;

endpackage

FILE: rtl/bucket_spray_chunk_chainer_top.sv
// bucket spray and chunk chainer: top level with the per-bucket state memory
// depends on bscc_pkg
//
// usage
//   request channel: drive i_req_type and the payload ports with i_start high;
//   a request is taken at a rising edge where i_start is high and o_busy low
//   request kinds: start (loads the log address), clump (places one entry in
//   its bucket, maybe flushes the bucket chunk), finish (flushes one bucket)
//   result channel: every result shows on the o_ ports for one cycle with
//   o_strobe high; o_last marks the final result of a request
//   the receiver cannot stall, results are never held back or repeated
//   the result is registered through the read and execute states; a second
//   (flush) result follows in the very next cycle
//   no new request is taken until the current one is through (o_busy high),
//   as the bucket memory is read, modified and written back per request
//   configuration: chunk_bytes written through i_cfg_valid / o_cfg_ready while
//   idle and no request is offered; the usable chunk size is then recomputed
//   by a reciprocal multiply and a scale, in the divide and scale states with o_busy high
//   reset: synchronous, active low; every bucket reads as empty with no chain
//   through per-bucket valid bits, so no clearing pass is needed
//   unknown request codes are taken and dropped without a result
module bucket_spray_chunk_chainer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [1:0]                  i_req_type,
    input  logic [63:0]                 i_base_addr,
    input  logic [31:0]                 i_score_prefix,
    input  logic [15:0]                 i_stored_size,
    input  logic [7:0]                  i_bucket_select,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bscc_pkg::CHUNK_W-1:0] i_cfg_data,
    output logic                        o_strobe,
    output logic [1:0]                  o_kind,
    output logic [7:0]                  o_bucket,
    output logic [bscc_pkg::CHUNK_W-1:0] o_slot_offset,
    output logic [63:0]                 o_entry_addr,
    output logic [7:0]                  o_entry_blocks,
    output logic [31:0]                 o_chunk_number,
    output logic [31:0]                 o_prev_link,
    output logic [bscc_pkg::CHUNK_W-1:0] o_byte_count,
    output logic [63:0]                 o_bucket_total,
    output logic [63:0]                 o_largest_total,
    output logic                        o_last
);
    import bscc_pkg::*;

    // control state
    t_state                 r_state, n_state;
    logic [NBUCKETS-1:0]    r_valid, n_valid;
    logic                   r_strobe, n_strobe;
    logic [CHUNK_W-1:0]     r_usable, n_usable;
    logic [31:0]            r_counter, n_counter;
    logic [63:0]            r_next_addr, n_next_addr;
    logic [63:0]            r_max, n_max;

    // payload registers
    logic [1:0]             r_req, n_req;
    logic [BUCKET_BITS-1:0] r_bucket, n_bucket;
    logic [SPAN_W-1:0]      r_span, n_span;
    logic [CHUNK_W-1:0]     r_div_x, n_div_x;
    t_result                r_res, n_res;
    t_result                r_pend, n_pend;

    // bucket memory
    t_entry                 r_mem [NBUCKETS];
    t_entry                 r_rd_data;
    logic                   mem_re;
    logic [BUCKET_BITS-1:0] mem_raddr;
    logic                   mem_we;
    t_entry                 mem_wdata;

    // datapath temporaries
    logic                   accept;
    logic                   cfg_acc;
    t_entry                 ent;
    logic [CHUNK_W-1:0]     nf;
    logic                   full;
    logic [CHUNK_W-1:0]     add_amt;
    logic [63:0]            sum_total;
    logic [SPAN_W:0]        blk_sum;
    logic [SPAN_W:0]        blk_raw;
    logic [7:0]             blocks;
    logic [CHUNK_W+DIV_MULT_W-1:0] div_prod;
    logic [CHUNK_W-1:0]     div_quot;

    assign accept  = i_start && (r_state == S_IDLE);
    assign cfg_acc = i_cfg_valid && o_cfg_ready;

    // a request offered while idle wins, the chunk size write waits
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_start;

    // request-side bucket pick, used as memory read address
    always_comb begin
        if (i_req_type == REQ_FINISH) begin
            mem_raddr = BUCKET_BITS'(i_bucket_select);
        end else begin
            mem_raddr = i_score_prefix[31 -: BUCKET_BITS];
        end
    end
    assign mem_re = accept;

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_bucket] <= mem_wdata;
        end
    end

    // never-written buckets read as empty with no chain
    assign ent = r_valid[r_bucket] ? r_rd_data : ENTRY_RESET;

    // clump arithmetic
    assign nf      = ent.fill + CHUNK_W'(ENTRY_BYTES);
    assign full    = ({1'b0, nf} + (CHUNK_W+1)'(ENTRY_BYTES)) > {1'b0, r_usable};
    assign add_amt = (r_req == REQ_CLUMP) ? nf : ent.fill;
    assign sum_total = ent.total + 64'(add_amt);
    assign blk_sum = {1'b0, r_span} + (SPAN_W+1)'((1 << BLOCK_LOG) - 1);
    assign blk_raw = blk_sum >> BLOCK_LOG;
    assign blocks  = (blk_raw > (SPAN_W+1)'(255)) ? 8'd255 : blk_raw[7:0];

    // whole entries in the chunk after the link word, by reciprocal multiply
    assign div_prod = (CHUNK_W+DIV_MULT_W)'(r_div_x) * (CHUNK_W+DIV_MULT_W)'(DIV_MULT);
    assign div_quot = CHUNK_W'(div_prod >> DIV_SHIFT);

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_strobe    = 1'b0;
        n_usable    = r_usable;
        n_counter   = r_counter;
        n_next_addr = r_next_addr;
        n_max       = r_max;
        n_req       = r_req;
        n_bucket    = r_bucket;
        n_span      = r_span;
        n_div_x     = r_div_x;
        n_res       = r_res;
        n_pend      = r_pend;
        mem_we      = 1'b0;
        mem_wdata   = ent;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req    = i_req_type;
                    n_bucket = mem_raddr;
                    n_span   = SPAN_W'(i_stored_size) + SPAN_W'(HEADER_BYTES);
                    if (i_req_type == REQ_START) begin
                        n_next_addr = i_base_addr;
                    end
                    n_state = S_READ;
                end else if (cfg_acc) begin
                    n_div_x   = (i_cfg_data >= CHUNK_W'(LINK_BYTES))
                                ? i_cfg_data - CHUNK_W'(LINK_BYTES) : '0;
                    n_state   = S_DIV;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_res   = '0;
                n_res.bucket = 8'(r_bucket);
                n_res.last   = 1'b1;
                n_state = S_IDLE;
                case (r_req)
                    REQ_START: begin
                        n_res.kind   = KIND_ACK;
                        n_res.bucket = '0;
                        n_strobe     = 1'b1;
                    end
                    REQ_CLUMP: begin
                        n_res.kind         = KIND_ENTRY;
                        n_res.slot_offset  = ent.fill;
                        n_res.entry_addr   = r_next_addr;
                        n_res.entry_blocks = blocks;
                        n_res.last         = !full;
                        n_strobe           = 1'b1;
                        n_next_addr        = r_next_addr + 64'(r_span);
                        mem_we             = 1'b1;
                        n_valid[r_bucket]  = 1'b1;
                        mem_wdata.fill     = nf;
                        if (full) begin
                            mem_wdata.fill     = '0;
                            mem_wdata.head     = r_counter;
                            mem_wdata.total    = sum_total;
                            n_counter          = r_counter + 32'd1;
                            n_pend             = '0;
                            n_pend.kind        = KIND_FLUSH;
                            n_pend.bucket      = 8'(r_bucket);
                            n_pend.chunk_number = r_counter;
                            n_pend.prev_link   = ent.head;
                            n_pend.byte_count  = nf;
                            n_pend.bucket_total = sum_total;
                            n_pend.last        = 1'b1;
                            n_state            = S_SECOND;
                        end
                    end
                    REQ_FINISH: begin
                        n_strobe = 1'b1;
                        if (ent.fill != '0) begin
                            mem_we             = 1'b1;
                            n_valid[r_bucket]  = 1'b1;
                            mem_wdata.head     = r_counter;
                            mem_wdata.total    = sum_total;
                            n_counter          = r_counter + 32'd1;
                            n_max              = (sum_total > r_max) ? sum_total : r_max;
                            n_res.kind         = KIND_FLUSH;
                            n_res.chunk_number = r_counter;
                            n_res.prev_link    = ent.head;
                            n_res.byte_count   = ent.fill;
                            n_res.bucket_total = sum_total;
                            n_res.largest_total = n_max;
                        end else begin
                            n_max              = (ent.total > r_max) ? ent.total : r_max;
                            n_res.kind         = KIND_EMPTY;
                            n_res.bucket_total = ent.total;
                            n_res.largest_total = n_max;
                        end
                    end
                    default: begin
                        n_res = r_res;
                    end
                endcase
            end
            S_SECOND: begin
                n_res    = r_pend;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_DIV: begin
                // entry count held until the scale step
                n_div_x = div_quot;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_usable = r_div_x * CHUNK_W'(ENTRY_BYTES);
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_strobe    <= 1'b0;
            r_usable    <= CHUNK_W'(USABLE_RESET);
            r_counter   <= '0;
            r_next_addr <= '0;
            r_max       <= '0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_strobe    <= n_strobe;
            r_usable    <= n_usable;
            r_counter   <= n_counter;
            r_next_addr <= n_next_addr;
            r_max       <= n_max;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_bucket <= n_bucket;
        r_span   <= n_span;
        r_div_x  <= n_div_x;
        r_res    <= n_res;
        r_pend   <= n_pend;
    end

    assign o_strobe        = r_strobe;
    assign o_kind          = r_res.kind;
    assign o_bucket        = r_res.bucket;
    assign o_slot_offset   = r_res.slot_offset;
    assign o_entry_addr    = r_res.entry_addr;
    assign o_entry_blocks  = r_res.entry_blocks;
    assign o_chunk_number  = r_res.chunk_number;
    assign o_prev_link     = r_res.prev_link;
    assign o_byte_count    = r_res.byte_count;
    assign o_bucket_total  = r_res.bucket_total;
    assign o_largest_total = r_res.largest_total;
    assign o_last          = r_res.last;

    // a non-final result is always followed by the final flush result
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> (o_strobe && o_last && o_kind == KIND_FLUSH))
        else $error("missing flush after non-final result");

    // a config write starts the usable-size recompute
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (o_busy && r_state == S_DIV))
        else $error("config write did not start recompute");

    // memory data is only consumed right after its read
    a_exec_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> ($past(r_state) == S_READ))
        else $error("exec without preceding read");

    // results strobe only while the block is finishing a request
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == S_EXEC || $past(r_state) == S_SECOND))
        else $error("result strobe outside request processing");

endmodule
